FILE: hdl/sbc_pkg.sv
package sbc_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int CW            = 24;   // coordinate width
  localparam int CFG_W         = 15;   // config register width
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] IMG_WIDTH_RST  = 15'd640;
  localparam logic [CFG_W-1:0] IMG_HEIGHT_RST = 15'd480;
  localparam logic [CW-1:0]    COORD_MAX      = 24'h7FFFFF;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // divider: 25 quotient bits, 5 per stage
  localparam int QW         = 25;
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = QW / DIV_STEPS;

  typedef struct packed {
    logic                 found;
    logic [1:0]           edge_idx;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] cx2;
    logic signed [CW-1:0] cy2;
  } sbc_side_t;

  // quotient wanted is round(-pnum / den)
  typedef struct packed {
    logic signed [49:0] pnum;
    logic signed [24:0] den;
    sbc_side_t          side;
  } sbc_divreq_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          neg;
    sbc_side_t     side;
  } sbc_divres_t;

endpackage

FILE: hdl/sbc_geom.sv
module sbc_geom import sbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_ix,
  input  logic signed [CW-1:0] in_iy,
  input  logic signed [CW-1:0] in_ox,
  input  logic signed [CW-1:0] in_oy,
  input  logic signed [CW-1:0] rlim,
  input  logic signed [CW-1:0] blim,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbc_divreq_t          out_req
);

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [CW-1:0] v,
                                                   input logic signed [CW-1:0] hi);
    if (v < 0) return '0;
    if (v > hi) return hi;
    return v;
  endfunction

  // 0 <= n/d <= 1, d nonzero
  function automatic logic unit_ratio(input logic signed [50:0] n,
                                      input logic signed [50:0] d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v4;

  // stage 1: clamp, differences, doubled midpoint offsets
  logic signed [CW-1:0] x1c, y1c;
  logic signed [CW-1:0] s1_x1, s1_y1, s1_x2, s1_y2, s1_r, s1_b, s1_cx2, s1_cy2;
  logic signed [24:0]   s1_dx, s1_dy, s1_xr, s1_yb;
  logic signed [26:0]   s1_mx0, s1_mx1, s1_mx3, s1_my0, s1_my1, s1_my2;

  assign x1c = clamp_c(in_ix, rlim);
  assign y1c = clamp_c(in_iy, blim);

  // stage 2: products
  logic signed [49:0]   s2_pa, s2_pb, s2_pc, s2_pd, s2_dr, s2_db;
  logic [53:0]          s2_sx0, s2_sx1, s2_sx3, s2_sy0, s2_sy1, s2_sy2;
  logic signed [CW-1:0] s2_x1, s2_y1, s2_r, s2_b, s2_cx2, s2_cy2;
  logic signed [24:0]   s2_dx, s2_dy;

  // stage 3: per-edge hit test and distance
  logic signed [49:0]   den0, den1, den2, den3;
  logic signed [50:0]   nub0, nub1, nub2, nub3;
  logic [3:0]           s3_hit;
  logic [53:0]          s3_d0, s3_d1, s3_d2, s3_d3;
  logic signed [49:0]   s3_pa, s3_pb, s3_pc, s3_pd;
  logic signed [24:0]   s3_dx, s3_dy;
  logic signed [CW-1:0] s3_x1, s3_y1, s3_r, s3_b, s3_cx2, s3_cy2;

  assign den0 = -s2_dr;
  assign den1 = s2_db;
  assign den2 = s2_dr;
  assign den3 = -s2_db;
  assign nub0 = 51'(s2_pa) - 51'(s2_pc);
  assign nub1 = 51'(s2_pa) - 51'(s2_pd);
  assign nub2 = 51'(s2_pb) - 51'(s2_pd);
  assign nub3 = 51'(s2_pb) - 51'(s2_pc);

  // stage 4: nearest hit edge, ties to the lower index
  logic        pick01, pick23, pickl, h01, h23;
  logic [53:0] d01, d23;
  logic [1:0]  i01, i23, best;
  sbc_divreq_t req;

  always_comb begin
    pick01 = !s3_hit[1] || (s3_hit[0] && (s3_d0 <= s3_d1));
    pick23 = !s3_hit[3] || (s3_hit[2] && (s3_d2 <= s3_d3));
    h01    = s3_hit[0] || s3_hit[1];
    h23    = s3_hit[2] || s3_hit[3];
    d01    = pick01 ? s3_d0 : s3_d1;
    d23    = pick23 ? s3_d2 : s3_d3;
    i01    = pick01 ? EDGE_TOP : EDGE_RIGHT;
    i23    = pick23 ? EDGE_BOTTOM : EDGE_LEFT;
    pickl  = !h23 || (h01 && (d01 <= d23));
    best   = (h01 || h23) ? (pickl ? i01 : i23) : EDGE_TOP;

    req.side.found    = h01 || h23;
    req.side.edge_idx = best;
    req.side.x1       = s3_x1;
    req.side.y1       = s3_y1;
    req.side.r        = s3_r;
    req.side.b        = s3_b;
    req.side.cx2      = s3_cx2;
    req.side.cy2      = s3_cy2;
    case (best)
      EDGE_TOP:    begin req.pnum = s3_pa; req.den = s3_dy; end
      EDGE_RIGHT:  begin req.pnum = s3_pd; req.den = s3_dx; end
      EDGE_BOTTOM: begin req.pnum = s3_pb; req.den = s3_dy; end
      EDGE_LEFT:   begin req.pnum = s3_pc; req.den = s3_dx; end
      default:     begin req.pnum = s3_pa; req.den = s3_dy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end

    if (en1) begin
      s1_x1  <= x1c;
      s1_y1  <= y1c;
      s1_x2  <= in_ox;
      s1_y2  <= in_oy;
      s1_r   <= rlim;
      s1_b   <= blim;
      s1_cx2 <= clamp_c(in_ox, rlim);
      s1_cy2 <= clamp_c(in_oy, blim);
      s1_dx  <= 25'(in_ox) - 25'(x1c);
      s1_dy  <= 25'(in_oy) - 25'(y1c);
      s1_xr  <= 25'(x1c) - 25'(rlim);
      s1_yb  <= 25'(y1c) - 25'(blim);
      s1_mx0 <= 27'(rlim) - (27'(in_ox) <<< 1);
      s1_mx1 <= (27'(rlim) <<< 1) - (27'(in_ox) <<< 1);
      s1_mx3 <= -(27'(in_ox) <<< 1);
      s1_my0 <= -(27'(in_oy) <<< 1);
      s1_my1 <= 27'(blim) - (27'(in_oy) <<< 1);
      s1_my2 <= (27'(blim) <<< 1) - (27'(in_oy) <<< 1);
    end

    if (en2) begin
      s2_pa  <= 50'(s1_dx) * 50'(s1_y1);
      s2_pb  <= 50'(s1_dx) * 50'(s1_yb);
      s2_pc  <= 50'(s1_dy) * 50'(s1_x1);
      s2_pd  <= 50'(s1_dy) * 50'(s1_xr);
      s2_dr  <= 50'(s1_r) * 50'(s1_dy);
      s2_db  <= 50'(s1_b) * 50'(s1_dx);
      s2_sx0 <= 54'(s1_mx0) * 54'(s1_mx0);
      s2_sx1 <= 54'(s1_mx1) * 54'(s1_mx1);
      s2_sx3 <= 54'(s1_mx3) * 54'(s1_mx3);
      s2_sy0 <= 54'(s1_my0) * 54'(s1_my0);
      s2_sy1 <= 54'(s1_my1) * 54'(s1_my1);
      s2_sy2 <= 54'(s1_my2) * 54'(s1_my2);
      s2_x1  <= s1_x1;
      s2_y1  <= s1_y1;
      s2_r   <= s1_r;
      s2_b   <= s1_b;
      s2_cx2 <= s1_cx2;
      s2_cy2 <= s1_cy2;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
    end

    if (en3) begin
      s3_hit[0] <= (s2_dr != 0) && unit_ratio(-(51'(s2_y1)), 51'(s2_dy))
                   && unit_ratio(nub0, 51'(den0));
      s3_hit[1] <= (s2_db != 0) && unit_ratio(51'(s2_r) - 51'(s2_x1), 51'(s2_dx))
                   && unit_ratio(nub1, 51'(den1));
      s3_hit[2] <= (s2_dr != 0) && unit_ratio(51'(s2_b) - 51'(s2_y1), 51'(s2_dy))
                   && unit_ratio(nub2, 51'(den2));
      s3_hit[3] <= (s2_db != 0) && unit_ratio(-(51'(s2_x1)), 51'(s2_dx))
                   && unit_ratio(nub3, 51'(den3));
      s3_d0  <= s2_sx0 + s2_sy0;
      s3_d1  <= s2_sx1 + s2_sy1;
      s3_d2  <= s2_sx0 + s2_sy2;
      s3_d3  <= s2_sx3 + s2_sy1;
      s3_pa  <= s2_pa;
      s3_pb  <= s2_pb;
      s3_pc  <= s2_pc;
      s3_pd  <= s2_pd;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_x1  <= s2_x1;
      s3_y1  <= s2_y1;
      s3_r   <= s2_r;
      s3_b   <= s2_b;
      s3_cx2 <= s2_cx2;
      s3_cy2 <= s2_cy2;
    end

    if (en4) out_req <= req;
  end

endmodule

FILE: hdl/sbc_div.sv
module sbc_div import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sbc_divreq_t in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output sbc_divres_t out_res
);

  // restoring division of magnitudes, rounding by adding half the divisor first
  typedef struct packed {
    logic [24:0]   rem;
    logic [24:0]   low;
    logic [QW-1:0] q;
    logic [24:0]   ad;
    logic          neg;
    sbc_side_t     side;
  } dstage_t;

  function automatic dstage_t div_steps(input dstage_t a);
    dstage_t    s;
    logic [25:0] t;
    s = a;
    for (int j = 0; j < DIV_STEPS; j++) begin
      t     = {s.rem, s.low[24]};
      s.low = {s.low[23:0], 1'b0};
      if (t >= {1'b0, s.ad}) begin
        s.rem = 25'(t - {1'b0, s.ad});
        s.q   = {s.q[QW-2:0], 1'b1};
      end else begin
        s.rem = t[24:0];
        s.q   = {s.q[QW-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  dstage_t             st [0:DIV_STAGES];
  logic [DIV_STAGES:0] v;
  logic [DIV_STAGES:0] en;

  logic [49:0] an, dsum;
  logic [24:0] ad;
  dstage_t     prep;

  always_comb begin
    an   = in_req.pnum[49] ? 50'(-in_req.pnum) : 50'(in_req.pnum);
    ad   = in_req.den[24] ? 25'(-in_req.den) : 25'(in_req.den);
    dsum = an + 50'(ad >> 1);
    prep.rem  = dsum[49:25];
    prep.low  = dsum[24:0];
    prep.q    = '0;
    prep.ad   = ad;
    prep.neg  = (!in_req.pnum[49] && (in_req.pnum != 0)) != in_req.den[24];
    prep.side = in_req.side;
  end

  always_comb begin
    en[DIV_STAGES] = !v[DIV_STAGES] || out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_ready      = en[0];
  assign out_valid     = v[DIV_STAGES];
  assign out_res.q     = st[DIV_STAGES].q;
  assign out_res.neg   = st[DIV_STAGES].neg;
  assign out_res.side  = st[DIV_STAGES].side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
    if (en[0]) st[0] <= prep;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) st[k] <= div_steps(st[k-1]);
    end
  end

endmodule

FILE: hdl/segment_border_clip.sv
// Channel  Dir  Handshake          Payload (low bit first)
// s_*      in   s_tvalid/s_tready  tdata: inside_x, inside_y, outside_x, outside_y
// m_*      out  m_tvalid/m_tready  tdata: clip_x, clip_y, edge_index; tuser: found
// cfg_*    in   cfg_we             cfg_index: 0 img_width, 1 img_height
//
// One item per cycle sustained while m_tready stays high; the path runs through 4 geometry
// stages, divider prep plus 5 divider stages (5 quotient bits each), and the output register.
// Synchronous reset clears all valid bits and loads 640x480.
// Each stage holds only while it is full and the next one is stalled, so
// bubbles get squeezed out and input is taken while a result waits on m_*.
module segment_border_clip import sbc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // inside_x, inside_y, outside_x, outside_y
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // clip_x, clip_y, edge_index, 6'b0
  output logic                 m_tuser,   // found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int EW = (CFG_W + FRAC_BITS > CW) ? CFG_W + FRAC_BITS : CW;

  // edge coordinate (size-1) in fixed point, saturated to the coordinate range
  function automatic logic signed [CW-1:0] edge_lim(input logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] sm1;
    logic [EW-1:0]    e;
    sm1 = (s == '0) ? '0 : s - 1'b1;
    e   = EW'(sm1) << FRAC_BITS;
    if (e > EW'(COORD_MAX)) return COORD_MAX;
    return CW'(e);
  endfunction

  logic [CFG_W-1:0]     img_width, img_height;
  logic signed [CW-1:0] rlim, blim;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= IMG_WIDTH_RST;
      img_height <= IMG_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH:  img_width  <= cfg_data;
        REG_IMG_HEIGHT: img_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // border coordinates follow the size registers, so a new size applies
  // to the very next item
  assign rlim = edge_lim(img_width);
  assign blim = edge_lim(img_height);

  logic        g_valid, g_ready;
  sbc_divreq_t g_req;
  logic        d_valid, d_ready;
  sbc_divres_t d_res;

  sbc_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ix     (s_tdata[23:0]),
    .in_iy     (s_tdata[47:24]),
    .in_ox     (s_tdata[71:48]),
    .in_oy     (s_tdata[95:72]),
    .rlim      (rlim),
    .blim      (blim),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_req   (g_req)
  );

  sbc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_req    (g_req),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_res   (d_res)
  );

  // final stage: apply the rounded quotient, handle the hit-at-start case
  logic                 en_o;
  logic signed [25:0]   sq;
  logic signed [CW-1:0] x3, y3, hx, hy, px, py;
  logic                 at_start;
  sbc_side_t            sd;

  assign sd   = d_res.side;
  assign en_o = !m_tvalid || m_tready;
  assign d_ready = en_o;

  always_comb begin
    sq = d_res.neg ? -(26'(d_res.q)) : 26'(d_res.q);
    x3 = (sd.edge_idx == EDGE_RIGHT) ? sd.r : '0;
    y3 = (sd.edge_idx == EDGE_BOTTOM) ? sd.b : '0;
    if (!sd.edge_idx[0]) begin
      // horizontal edge: y is the edge line
      hx       = CW'(26'(sd.x1) + sq);
      hy       = y3;
      at_start = (sq == 0) && (sd.y1 == y3);
      px       = at_start ? sd.cx2 : hx;
      py       = hy;
    end else begin
      hx       = x3;
      hy       = CW'(26'(sd.y1) + sq);
      at_start = (sq == 0) && (sd.x1 == x3);
      px       = hx;
      py       = at_start ? sd.cy2 : hy;
    end
    if (!sd.found) begin
      px = sd.x1;
      py = sd.y1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_o) begin
      m_tvalid <= d_valid;
    end
    if (en_o) begin
      m_tdata <= {6'b0, (sd.found ? sd.edge_idx : EDGE_TOP), py, px};
      m_tuser <= sd.found;
    end
  end

  // no hit reports the top edge code
  a_nohit_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[49:48] == EDGE_TOP)
    else $error("edge index set without a hit");

  // an empty output register means the whole pipe can take an item
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

  // the edge-line coordinate of a hit lies on the border, never negative
  a_edge_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[48] ? !m_tdata[23] : !m_tdata[47]))
    else $error("hit point off the border line");

endmodule

FILE: tb/segment_border_clip_test.sv
module segment_border_clip_test;
  import sbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FB        = 8;
  localparam int  CYC_LIMIT = 400000;
  localparam int  N_RANDOM  = 930;
  localparam int  DRAIN     = 30;      // margin after the last result, beyond the output latency
  localparam int  HOLD_LEN  = 300;     // long receiver hold-off

  // Expected results and the block's behavior, computed per accepted item.
  class clip_scoreboard;
    typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [1:0]    edge_idx;
      logic          found;
    } clip_t;

    clip_t         pending_clips[$];
    int            errors;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;

    function new();
      errors = 0;
      width  = IMG_WIDTH_RST;
      height = IMG_HEIGHT_RST;
    endfunction

    // border coordinate in Q format; zero size acts as one, big sizes saturate
    function longint border(logic [CFG_W-1:0] sz);
      longint s, e;
      s = sz;
      if (s < 1) s = 1;
      e = (s - 1) << FB;
      return (e > 8388607) ? 8388607 : e;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // round to nearest, halves away from zero
    function longint round_div(longint num, longint den);
      longint an, ad, q;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q  = (an + ad / 2) / ad;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function bit in_unit(longint n, longint d);
      if (d > 0) return n >= 0 && n <= d;
      return n <= 0 && n >= d;
    endfunction

    function clip_t project(logic [95:0] q);
      longint r, b, x1, y1, x2, y2, px, py, best_d;
      longint cx[4], cy[4];
      longint x3, y3, x4, y4, den, nua, nub, hx, hy, dx, dy, d;
      int     best;
      clip_t  c;
      r  = border(width);
      b  = border(height);
      x1 = $signed(q[23:0]);
      y1 = $signed(q[47:24]);
      x2 = $signed(q[71:48]);
      y2 = $signed(q[95:72]);
      x1 = clampl(x1, 0, r);
      y1 = clampl(y1, 0, b);
      cx[0] = 0; cy[0] = 0;
      cx[1] = r; cy[1] = 0;
      cx[2] = r; cy[2] = b;
      cx[3] = 0; cy[3] = b;
      px = x1; py = y1; best = -1; best_d = 0;
      // edges clockwise from the top; nearest midpoint to the outside point wins
      for (int i = 0; i < 4; i++) begin
        x3 = cx[i]; y3 = cy[i];
        x4 = cx[(i + 1) % 4]; y4 = cy[(i + 1) % 4];
        den = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
        nua = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
        nub = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
        if (den != 0 && in_unit(nua, den) && in_unit(nub, den)) begin
          if (i % 2 == 0) begin
            hy = y3;
            hx = x1 + round_div((y3 - y1) * (x2 - x1), y2 - y1);
          end else begin
            hx = x3;
            hy = y1 + round_div((x3 - x1) * (y2 - y1), x2 - x1);
          end
          dx = x3 + x4 - 2 * x2;
          dy = y3 + y4 - 2 * y2;
          d  = dx * dx + dy * dy;
          if (best < 0 || d < best_d) begin
            best = i; best_d = d; px = hx; py = hy;
          end
        end
      end
      // hit right at the start point: slide the outside point along the edge
      if (best >= 0 && px == x1 && py == y1) begin
        x3 = cx[best]; y3 = cy[best];
        x4 = cx[(best + 1) % 4]; y4 = cy[(best + 1) % 4];
        if (x3 == x4) begin
          px = x3;
          py = clampl(y2, 0, (y3 > y4) ? y3 : y4);
        end else begin
          px = clampl(x2, 0, (x3 > x4) ? x3 : x4);
          py = y3;
        end
      end
      c.x        = px[CW-1:0];
      c.y        = py[CW-1:0];
      c.edge_idx = (best >= 0) ? best[1:0] : EDGE_TOP;
      c.found    = (best >= 0);
      return c;
    endfunction

    function void note_query(logic [95:0] q);
      pending_clips = {pending_clips, project(q)};
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task check_result(logic [55:0] t, logic u);
      clip_t e;
      if (pending_clips.size() == 0) begin
        report("unexpected item", t, 0);
        return;
      end
      e = pending_clips.pop_front();
      if (t[23:0] !== e.x) report("clip_x", t[23:0], e.x);
      if (t[47:24] !== e.y) report("clip_y", t[47:24], e.y);
      if (t[49:48] !== e.edge_idx) report("edge_index", t[49:48], e.edge_idx);
      if (t[55:50] !== 6'b0) report("tdata pad", t[55:50], 0);
      if (u !== e.found) report("found", u, e.found);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;   // inside_x, inside_y, outside_x, outside_y
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;        // clip_x, clip_y, edge_index, pad
  logic                 m_tuser;        // found
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMG_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  clip_scoreboard sb = new();
  int  send_idle = 20;    // percent of chances the sender stays idle
  int  recv_idle = 86;    // percent of cycles the receiver stalls
  bit  hold_req  = 1'b0;
  int  cyc       = 0;

  segment_border_clip dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_cnt == 0) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

  // offer one item; valid stays high into the next item when there is no gap
  task send_query(logic [23:0] ix, logic [23:0] iy, logic [23:0] ox, logic [23:0] oy);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {oy, ox, iy, ix};
    do @(posedge clk); while (!s_tready);
    sb.note_query({oy, ox, iy, ix});
  endtask

  // sizes change only with the pipe empty
  task set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_clips.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.width  = w;
    sb.height = h;
  endtask

  function logic [23:0] px(int p);
    return 24'(p <<< FB);
  endfunction

  function logic [23:0] sat24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // coordinate around a border span [0, lim]: inside, on it, or past it
  function logic [23:0] near_coord(longint lim, bit outward);
    longint m;
    m = lim / 2 + 2000;
    case ($urandom_range(5))
      0: return sat24(0);
      1: return sat24(lim);
      default: begin
        if (!outward) return sat24($urandom_range(lim));
        if ($urandom_range(1)) return sat24(lim + 1 + $urandom_range(m));
        return sat24(-1 - longint'($urandom_range(m)));
      end
    endcase
  endfunction

  task random_query();
    longint r, b;
    logic [23:0] ix, iy, ox, oy;
    int mode;
    r = sb.border(sb.width);
    b = sb.border(sb.height);
    mode = $urandom_range(99);
    if (mode < 75) begin
      // well-formed: start in or near the box, cursor beyond one or two borders
      ix = ($urandom_range(9) == 0) ? near_coord(r, 1) : near_coord(r, 0);
      iy = ($urandom_range(9) == 0) ? near_coord(b, 1) : near_coord(b, 0);
      case ($urandom_range(2))
        0: begin ox = near_coord(r, 1); oy = near_coord(b, 0); end
        1: begin ox = near_coord(r, 0); oy = near_coord(b, 1); end
        default: begin ox = near_coord(r, 1); oy = near_coord(b, 1); end
      endcase
    end else if (mode < 85) begin
      // axis-aligned moves give parallel edges and hits on the start point
      ix = near_coord(r, 0);
      iy = near_coord(b, 0);
      ox = $urandom_range(1) ? ix : near_coord(r, 1);
      oy = (ox == ix) ? near_coord(b, 1) : iy;
    end else begin
      ix = 24'($urandom); iy = 24'($urandom); ox = 24'($urandom); oy = 24'($urandom);
    end
    send_query(ix, iy, ox, oy);
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset size 640x480
    send_query(px(100), px(100), px(-50), px(200));        // left edge
    send_query(px(320), px(240), px(700), px(-100));       // top or right
    send_query(px(320), px(240), px(-320), px(-240));      // through a corner
    send_query(px(320), px(0), px(320), px(-50));          // hit on start point
    send_query(px(639), px(100), px(700), px(100));        // start on right edge
    send_query(px(0), px(479), px(-10), px(600));          // start on a corner
    send_query(px(10), px(0), px(-100), px(0));            // parallel to top
    send_query(px(100), px(100), px(200), px(200));        // no edge hit
    send_query(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_query(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_query(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
    send_query(24'h000001, 24'h000081, 24'hFFFFFF, 24'h7FFFFF);
    send_query(px(-5), px(900), px(300), px(-300));        // start clamped

    // one pixel image: all edges degenerate
    set_size(15'd1, 15'd1);
    send_query(px(0), px(0), px(5), px(5));
    send_query(px(3), px(-3), px(-5), px(9));
    // zero size acts as one, width a single column
    set_size(15'd0, 15'd7);
    send_query(px(0), px(3), px(-4), px(3));
    send_query(px(0), px(2), px(4), px(-9));
    // largest size puts the borders near the top of the coordinate range
    set_size(15'h7FFF, 15'h7FFF);
    send_query(24'h7FFFFF, px(100), 24'h800000, px(100));
    send_query(px(500), px(500), 24'h800000, 24'h800000);
    send_query(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    set_size(15'd2, 15'h7FFF);
    send_query(px(1), px(30000), px(5), 24'h800000);

    // random part in ten size settings
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 93 == 0) begin
        case ($urandom_range(7))
          0: begin w = 1; h = $urandom_range(1, 5); end
          1: begin w = 32767; h = $urandom_range(1, 32767); end
          2: begin w = 640; h = 480; end
          default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
        endcase
        set_size(w[CFG_W-1:0], h[CFG_W-1:0]);
      end
      if (k == N_RANDOM / 3) begin
        send_idle = 86; recv_idle = 20;
      end
      if (k == 2 * N_RANDOM / 3) begin
        send_idle = 0; recv_idle = 0;
        hold_req = 1'b1;   // fill the pipe and back up the input
      end
      random_query();
    end
    s_tvalid <= 1'b0;

    while (sb.pending_clips.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
